// ===== hdl/size_class_pool_allocator_assert.svh =====
// assertion macros, clocked on clock and disabled while reset is high
`ifndef SIZE_CLASS_POOL_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_POOL_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define SCPA_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SCPA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/scpa_pkg.sv =====
`timescale 1ns / 1ps

package scpa_pkg;

   localparam int SIZE_W    = 16;
   localparam int COUNT_W   = 9;
   localparam int BLOCK_W   = 8;
   localparam int POOL_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_FIT = 2'd2;

   // register map: sizes of pools 0..3, then counts of pools 0..3
   localparam int CSR_SIZE_BASE  = 0;
   localparam int CSR_COUNT_BASE = 4;
   localparam int CSR_POOLS      = 4;

   localparam logic [COUNT_W-1:0] RESET_COUNT = 9'd256;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [POOL_W-1:0]   pool;
      logic                ok;
   } stage_type;

   function automatic logic [SIZE_W-1:0] reset_size(input int p);
      logic [SIZE_W-1:0] r;
      case (p)
         0:       r = 16'd16;
         1:       r = 16'd64;
         2:       r = 16'd256;
         3:       r = 16'd1024;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/scpa_if.sv =====
`timescale 1ns / 1ps

interface scpa_req_if;
   import scpa_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 operation;
   logic [SIZE_W-1:0]    request_size;
   logic [POOL_W-1:0]    free_pool;
   logic [BLOCK_W-1:0]   free_block;

   modport source (output valid, operation, request_size, free_pool, free_block,
                   input ready);
   modport sink   (input valid, operation, request_size, free_pool, free_block,
                   output ready);
endinterface

interface scpa_rsp_if;
   import scpa_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [POOL_W-1:0]    granted_pool;
   logic [BLOCK_W-1:0]   granted_block;

   modport source (output valid, status, granted_pool, granted_block, input ready);
   modport sink   (input valid, status, granted_pool, granted_block, output ready);
endinterface

interface scpa_csr_if;
   import scpa_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/size_class_pool_allocator.sv =====
`timescale 1ns / 1ps
// channel    | direction | payload
// req_chan   | in        | operation, request_size, free_pool, free_block
// rsp_chan   | out       | status, granted_pool, granted_block
// csr_chan   | in        | index, data (register write)
//
// each request passes through the free-list memory read (or write) at the
// accept edge, then the result capture into the output register
// a new request is taken while a finished result waits in the output register
// after reset the free lists are swept to identity; a block count write re-sweeps that pool;
// no request is accepted during a sweep; register writes are always taken

`include "size_class_pool_allocator_assert.svh"

module size_class_pool_allocator #(
   parameter int POOL_COUNT = 4,
   parameter int MAX_BLOCKS = 256
) (
   input logic         clock,
   input logic         reset,
   scpa_req_if.sink    req_chan,
   scpa_rsp_if.source  rsp_chan,
   scpa_csr_if.sink    csr_chan
);
   import scpa_pkg::*;

   localparam int PW         = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
   localparam int POOL_SLOTS = 1 << PW;
   localparam int IW         = $clog2(MAX_BLOCKS);
   localparam int CW         = $clog2(MAX_BLOCKS + 1);
   localparam int NW         = (CW > COUNT_W) ? CW : COUNT_W;
   localparam int AW         = PW + IW;
   localparam int MEM_DEPTH  = POOL_COUNT << IW;

   function automatic logic [CW-1:0] eff_count(input logic [NW-1:0] c);
      logic [CW-1:0] r;
      if (c == '0) begin
         r = CW'(1);
      end else if (32'(c) > 32'(MAX_BLOCKS)) begin
         r = CW'(MAX_BLOCKS);
      end else begin
         r = CW'(c);
      end
      return r;
   endfunction

   function automatic logic [NW-1:0] reset_count(input int p);
      logic [NW-1:0] r;
      if (p < CSR_POOLS) begin
         r = NW'(RESET_COUNT);
      end else begin
         r = NW'(MAX_BLOCKS);
      end
      return r;
   endfunction

   // configuration and per-pool state
   logic [SIZE_W-1:0]     size_ff    [POOL_SLOTS];
   logic [SIZE_W-1:0]     size_in    [POOL_SLOTS];
   logic [NW-1:0]         count_ff   [POOL_SLOTS];
   logic [NW-1:0]         count_in   [POOL_SLOTS];
   logic [IW-1:0]         pos_ff     [POOL_SLOTS];
   logic [IW-1:0]         pos_in     [POOL_SLOTS];
   logic [CW-1:0]         left_ff    [POOL_SLOTS];
   logic [CW-1:0]         left_in    [POOL_SLOTS];

   // clearing sweep
   logic [POOL_SLOTS-1:0] pending_ff;
   logic [POOL_SLOTS-1:0] pending_in;
   logic [PW-1:0]         sweep_pool_ff;
   logic [PW-1:0]         sweep_pool_in;
   logic [IW-1:0]         sweep_idx_ff;
   logic [IW-1:0]         sweep_idx_in;
   logic                  clearing;
   logic                  sweep_write;

   // free-list memory
   logic [BLOCK_W-1:0]    mem [MEM_DEPTH];
   logic [BLOCK_W-1:0]    rdata_ff;
   logic                  mem_we;
   logic                  mem_re;
   logic [AW-1:0]         waddr;
   logic [AW-1:0]         raddr;
   logic [BLOCK_W-1:0]    wdata;

   // request decode
   logic                  accept;
   logic                  csr_hit;
   logic                  fit_found;
   logic [PW-1:0]         fit_pool;
   logic                  free_ok;
   logic [PW-1:0]         tp;
   logic [IW-1:0]         cur_pos;
   logic [CW-1:0]         cur_cnt;
   logic [CW-1:0]         cur_left;
   logic                  pos_wrap;
   logic [IW-1:0]         alloc_pos;
   logic [IW-1:0]         alloc_next;
   logic [CW-1:0]         alloc_inc;
   logic [IW-1:0]         free_pos;
   logic                  alloc_ok;
   logic                  free_do;
   stage_type             st_new;

   // result path
   logic                  stage_ff;
   logic                  stage_in;
   stage_type             st_ff;
   logic                  drain;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [POOL_W-1:0]     rsp_pool_ff;
   logic [BLOCK_W-1:0]    rsp_block_ff;

   assign clearing = |pending_ff;
   assign accept   = req_chan.valid && req_chan.ready;
   assign csr_hit  = csr_chan.valid && csr_chan.ready;

   assign req_chan.ready = !stage_ff && !clearing;
   assign csr_chan.ready = 1'b1;

   // first pool whose block size fits
   always_comb begin
      fit_found = 1'b0;
      fit_pool  = '0;
      for (int p = POOL_COUNT - 1; p >= 0; p--) begin
         if (req_chan.request_size <= size_ff[p]) begin
            fit_found = 1'b1;
            fit_pool  = PW'(p);
         end
      end
   end

   always_comb begin
      free_ok   = 32'(req_chan.free_pool) < 32'(POOL_COUNT);
      tp        = (req_chan.operation == OP_FREE) ? PW'(req_chan.free_pool) : fit_pool;
      cur_pos   = pos_ff[tp];
      cur_cnt   = eff_count(count_ff[tp]);
      cur_left  = left_ff[tp];
      pos_wrap  = CW'(cur_pos) >= cur_cnt;
      alloc_pos = pos_wrap ? '0 : cur_pos;
      alloc_inc = CW'(alloc_pos) + CW'(1);
      alloc_next = (alloc_inc >= cur_cnt) ? '0 : IW'(alloc_inc);
      free_pos  = (cur_pos == '0 || pos_wrap) ? IW'(cur_cnt - CW'(1)) : cur_pos - IW'(1);
      alloc_ok  = accept && req_chan.operation == OP_ALLOC && fit_found && cur_left != '0;
      free_do   = accept && req_chan.operation == OP_FREE && free_ok;

      st_new.status = STATUS_OK;
      st_new.pool   = '0;
      st_new.ok     = 1'b0;
      if (req_chan.operation == OP_ALLOC) begin
         if (!fit_found) begin
            st_new.status = STATUS_NO_FIT;
         end else if (cur_left == '0) begin
            st_new.status = STATUS_EMPTY;
         end else begin
            st_new.pool = POOL_W'(fit_pool);
            st_new.ok   = 1'b1;
         end
      end
   end

   // per-pool state, register writes and sweep control
   always_comb begin
      size_in       = size_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      left_in       = left_ff;
      pending_in    = pending_ff;
      sweep_pool_in = sweep_pool_ff;
      sweep_idx_in  = sweep_idx_ff;

      if (alloc_ok) begin
         pos_in[tp]  = alloc_next;
         left_in[tp] = cur_left - CW'(1);
      end
      if (free_do) begin
         pos_in[tp] = free_pos;
         if (cur_left < cur_cnt) begin
            left_in[tp] = cur_left + CW'(1);
         end
      end

      if (clearing) begin
         if (pending_ff[sweep_pool_ff]) begin
            if (sweep_idx_ff == IW'(MAX_BLOCKS - 1)) begin
               pending_in[sweep_pool_ff] = 1'b0;
               sweep_idx_in  = '0;
               sweep_pool_in = (sweep_pool_ff == PW'(POOL_COUNT - 1)) ?
                               '0 : sweep_pool_ff + PW'(1);
            end else begin
               sweep_idx_in = sweep_idx_ff + IW'(1);
            end
         end else begin
            sweep_idx_in  = '0;
            sweep_pool_in = (sweep_pool_ff == PW'(POOL_COUNT - 1)) ?
                            '0 : sweep_pool_ff + PW'(1);
         end
      end

      for (int p = 0; p < POOL_COUNT; p++) begin
         if (p < CSR_POOLS && csr_hit) begin
            if (32'(csr_chan.index) == 32'(CSR_SIZE_BASE + p)) begin
               size_in[p] = csr_chan.data[SIZE_W-1:0];
            end
            if (32'(csr_chan.index) == 32'(CSR_COUNT_BASE + p)) begin
               count_in[p]   = NW'(csr_chan.data[COUNT_W-1:0]);
               pos_in[p]     = '0;
               left_in[p]    = eff_count(NW'(csr_chan.data[COUNT_W-1:0]));
               pending_in[p] = 1'b1;
               if (sweep_pool_ff == PW'(p)) begin
                  sweep_idx_in = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < POOL_SLOTS; p++) begin
            size_ff[p]  <= reset_size(p);
            count_ff[p] <= reset_count(p);
            pos_ff[p]   <= '0;
            left_ff[p]  <= eff_count(reset_count(p));
            pending_ff[p] <= p < POOL_COUNT;
         end
         sweep_pool_ff <= '0;
         sweep_idx_ff  <= '0;
      end else begin
         size_ff       <= size_in;
         count_ff      <= count_in;
         pos_ff        <= pos_in;
         left_ff       <= left_in;
         pending_ff    <= pending_in;
         sweep_pool_ff <= sweep_pool_in;
         sweep_idx_ff  <= sweep_idx_in;
      end
   end

   // memory ports: sweep or free writes, allocate reads
   always_comb begin
      sweep_write = clearing && pending_ff[sweep_pool_ff];
      mem_we = sweep_write || free_do;
      mem_re = alloc_ok;
      if (clearing) begin
         waddr = {sweep_pool_ff, sweep_idx_ff};
         wdata = BLOCK_W'(sweep_idx_ff);
      end else begin
         waddr = {tp, free_pos};
         wdata = req_chan.free_block;
      end
      raddr = {tp, alloc_pos};
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[raddr];
      end
   end

   // stage and output register
   assign drain = stage_ff && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      stage_in = stage_ff;
      if (accept) begin
         stage_in = 1'b1;
      end else if (drain) begin
         stage_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (drain) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stage_ff     <= stage_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         st_ff <= st_new;
      end
      if (drain) begin
         rsp_status_ff <= st_ff.status;
         rsp_pool_ff   <= st_ff.pool;
         rsp_block_ff  <= st_ff.ok ? rdata_ff : '0;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.granted_pool  = rsp_pool_ff;
   assign rsp_chan.granted_block = rsp_block_ff;

   `SCPA_ASSERT_NEXT(a_accept_blocks_next, accept, stage_ff && !req_chan.ready, "request taken while previous one in flight")
   `SCPA_ASSERT_IMPL(a_mem_one_access, mem_re, !mem_we, "free-list read and write in the same cycle")
   `SCPA_ASSERT_IMPL(a_fail_zero, rsp_valid_ff && rsp_status_ff != STATUS_OK, rsp_pool_ff == '0 && rsp_block_ff == '0, "failed allocate carries a block")
   `SCPA_ASSERT_IMPL(a_left_bounded, !clearing, left_ff[0] <= eff_count(count_ff[0]), "free count above block count")

endmodule
